// ----- hw/rtl/pear_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pear_pkg
// shared widths, constants, command and status types of the polyline resampler
// ----------------------------------------------------------------------------
package pear_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_OUTPUTS  = 64;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int CUM_W   = 32;
  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int N_W     = 7;
  localparam int S_W     = $clog2(MAX_OUTPUTS);
  localparam int MULA_W  = DIFF_W;
  localparam int MULB_W  = CUM_W;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int RAD_W   = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int ITER_W  = 6;

  localparam int DIV_STEPS  = PROD_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [N_W-1:0] OUTPUT_COUNT_RST = N_W'(10);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_SQADD,
    OP_SQRT_STEP,
    OP_CUM,
    OP_EMIT_START,
    OP_CAP_XY,
    OP_PUSH,
    OP_FINISH,
    OP_NEXT_S,
    OP_MUL_D,
    OP_DIVN_INIT,
    OP_DIV_STEP,
    OP_SET_D,
    OP_SRCH_RD,
    OP_ADV,
    OP_HIT,
    OP_CAP_LO,
    OP_CAP_HI,
    OP_RD_LAST,
    OP_MUL_X,
    OP_MUL_Y,
    OP_DIVL_INIT,
    OP_SET_X,
    OP_SET_Y
  } pear_op_t;

  typedef struct packed {
    pear_op_t op;
  } pear_cmd_t;

  typedef struct packed {
    logic stored;
    logic first;
    logic last;
    logic s_last;
    logic out_valid;
    logic idx_end;
    logic hit;
    logic len_zero;
  } pear_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pear_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pear channel interfaces
// valid/ready channels for vertices, resampled points and configuration
// ----------------------------------------------------------------------------
interface pear_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pear_pkg::COORD_W-1:0]  point_x;
  logic signed [pear_pkg::COORD_W-1:0]  point_y;
  logic                                 last_vertex;
  modport source (output valid, point_x, point_y, last_vertex, input ready);
  modport sink   (input valid, point_x, point_y, last_vertex, output ready);
endinterface

interface pear_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pear_pkg::COORD_W-1:0]  out_x;
  logic signed [pear_pkg::COORD_W-1:0]  out_y;
  logic                                 last_point;
  modport source (output valid, out_x, out_y, last_point, input ready);
  modport sink   (input valid, out_x, out_y, last_point, output ready);
endinterface

interface pear_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pear_pkg::N_W-1:0]     output_count;
  modport source (output valid, output_count, input ready);
  modport sink   (input valid, output_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/polyline_equal_arc_resample_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_equal_arc_resample_core
// equal arc length resampling of a polyline loaded one vertex per beat
// ----------------------------------------------------------------------------
// vertex: the 25-step square root gives each segment length; the first vertex skips it
// emission: first point taken from the first vertex; each further point needs a
//   segment search and up to three runs of the 57-step shared divider
// one vertex or one run of points at a time; each point waits for its out beat
// reset: vertex count 0, output_count 10; vertex and length rams not cleared
module polyline_equal_arc_resample_core (
  input  wire logic clk,
  input  wire logic rst_n,
  pear_in_if.sink   in_ch,
  pear_out_if.source out_ch,
  pear_cfg_if.sink  cfg_ch
);

  pear_pkg::pear_cmd_t cmd;
  pear_pkg::pear_sts_t sts;
  logic                in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  pear_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pear_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (in_ch.point_x),
    .in_y      (in_ch.point_y),
    .in_last   (in_ch.last_vertex),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.output_count),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_last  (out_ch.last_point)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/pear_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pear_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pear_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pear_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pear_dp
// datapath: vertex stores, shared multiplier, square root and divider units
// ----------------------------------------------------------------------------
module pear_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pear_pkg::pear_cmd_t                 cmd,
  output pear_pkg::pear_sts_t                      sts,
  input  wire logic signed [pear_pkg::COORD_W-1:0] in_x,
  input  wire logic signed [pear_pkg::COORD_W-1:0] in_y,
  input  wire logic                                in_last,
  input  wire logic                                cfg_we,
  input  wire logic [pear_pkg::N_W-1:0]            cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pear_pkg::COORD_W-1:0]      out_x,
  output logic signed [pear_pkg::COORD_W-1:0]      out_y,
  output logic                                     out_last
);

  localparam int CW = pear_pkg::COORD_W;
  localparam int DW = pear_pkg::DIFF_W;
  localparam int UW = pear_pkg::CUM_W;
  localparam int AW = pear_pkg::ADDR_W;
  localparam int KW = pear_pkg::CNT_W;
  localparam int NW = pear_pkg::N_W;
  localparam int SW = pear_pkg::S_W;
  localparam int PW = pear_pkg::PROD_W;
  localparam int RW = pear_pkg::RAD_W;
  localparam int OW = pear_pkg::ROOT_W;
  localparam int MW = pear_pkg::REM_W;

  logic [NW-1:0]        ocount_r;
  logic [KW-1:0]        cnt_r;
  logic                 stored_r, first_r, last_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic [UW-1:0]        prev_cum_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [PW-1:0]        prod_r;
  logic [RW-1:0]        rad_r;
  logic [OW-1:0]        root_r;
  logic [MW-1:0]        rem_r;
  logic [PW-1:0]        dq_r;
  logic [UW-1:0]        drem_r, dden_r;
  logic [NW-1:0]        n_r;
  logic [SW-1:0]        s_r;
  logic [KW-1:0]        idx_r;
  logic [UW-1:0]        d_r, hi_r, base_r, len_r, t_r;
  logic signed [CW-1:0] x0_r, y0_r, res_x_r, res_y_r;
  logic [DW-1:0]        mag_x_r, mag_y_r;
  logic                 neg_x_r, neg_y_r;
  logic                 out_valid_r, out_last_r;
  logic signed [CW-1:0] out_x_r, out_y_r;

  logic [CW-1:0]        x_rd, y_rd;
  logic [UW-1:0]        cum_rd;
  logic [AW-1:0]        raddr;
  logic                 xy_we, cum_we;
  logic [UW-1:0]        cum_wdata;

  logic [pear_pkg::MULA_W-1:0] mul_a;
  logic [pear_pkg::MULB_W-1:0] mul_b;
  logic [PW-1:0]        prod_nxt;
  logic [DW-1:0]        abs_dx, abs_dy;
  logic [MW-1:0]        rem_sh, trial;
  logic                 sq_ge;
  logic [UW:0]          dr_sh;
  logic                 dv_ge;
  logic signed [DW-1:0] dif_x, dif_y;
  logic [NW-1:0]        n_clamp;
  logic [UW:0]          cum_sum;
  logic                 can_store;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  pear_ram #(.WIDTH(CW), .DEPTH(pear_pkg::MAX_VERTICES)) u_xram (
    .clk(clk), .we(xy_we), .waddr(cnt_r[AW-1:0]), .wdata(in_x),
    .raddr(raddr), .rdata(x_rd)
  );
  pear_ram #(.WIDTH(CW), .DEPTH(pear_pkg::MAX_VERTICES)) u_yram (
    .clk(clk), .we(xy_we), .waddr(cnt_r[AW-1:0]), .wdata(in_y),
    .raddr(raddr), .rdata(y_rd)
  );
  pear_ram #(.WIDTH(UW), .DEPTH(pear_pkg::MAX_VERTICES)) u_cram (
    .clk(clk), .we(cum_we), .waddr(cnt_r[AW-1:0]), .wdata(cum_wdata),
    .raddr(raddr), .rdata(cum_rd)
  );

  assign can_store = cnt_r < KW'(pear_pkg::MAX_VERTICES);
  assign xy_we     = (cmd.op == pear_pkg::OP_LOAD) && can_store;
  assign cum_we    = (cmd.op == pear_pkg::OP_CUM);
  assign cum_sum   = {1'b0, prev_cum_r} + (UW + 1)'(root_r);
  assign cum_wdata = first_r ? '0 : (cum_sum[UW] ? '1 : cum_sum[UW-1:0]);

  assign abs_dx = mag(dx_r);
  assign abs_dy = mag(dy_r);
  assign dif_x  = {x_rd[CW-1], x_rd} - {x0_r[CW-1], x0_r};
  assign dif_y  = {y_rd[CW-1], y_rd} - {y0_r[CW-1], y0_r};

  assign rem_sh = {rem_r[MW-3:0], rad_r[RW-1:RW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  assign dr_sh  = {drem_r, dq_r[PW-1]};
  assign dv_ge  = dr_sh >= {1'b0, dden_r};

  always_comb begin
    if (ocount_r == '0) begin
      n_clamp = NW'(1);
    end else if (ocount_r > NW'(pear_pkg::MAX_OUTPUTS)) begin
      n_clamp = NW'(pear_pkg::MAX_OUTPUTS);
    end else begin
      n_clamp = ocount_r;
    end
  end

  always_comb begin
    raddr = '0;
    unique case (cmd.op)
      pear_pkg::OP_SRCH_RD,
      pear_pkg::OP_CAP_LO:  raddr = idx_r[AW-1:0];
      pear_pkg::OP_HIT:     raddr = AW'(idx_r - KW'(1));
      pear_pkg::OP_RD_LAST: raddr = AW'(cnt_r - KW'(1));
      default:              raddr = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pear_pkg::OP_SQX: begin
        mul_a = abs_dx;
        mul_b = UW'(abs_dx);
      end
      pear_pkg::OP_SQY: begin
        mul_a = abs_dy;
        mul_b = UW'(abs_dy);
      end
      pear_pkg::OP_MUL_D: begin
        mul_a = DW'(s_r);
        mul_b = prev_cum_r;
      end
      pear_pkg::OP_MUL_X: begin
        mul_a = mag_x_r;
        mul_b = t_r;
      end
      pear_pkg::OP_MUL_Y: begin
        mul_a = mag_y_r;
        mul_b = t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocount_r    <= pear_pkg::OUTPUT_COUNT_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ocount_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        pear_pkg::OP_CUM:    cnt_r <= cnt_r + KW'(1);
        pear_pkg::OP_FINISH: cnt_r <= '0;
        pear_pkg::OP_PUSH:   out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pear_pkg::OP_LOAD: begin
        stored_r <= can_store;
        first_r  <= cnt_r == '0;
        last_r   <= in_last;
        if (can_store) begin
          dx_r     <= {in_x[CW-1], in_x} - {prev_x_r[CW-1], prev_x_r};
          dy_r     <= {in_y[CW-1], in_y} - {prev_y_r[CW-1], prev_y_r};
          prev_x_r <= in_x;
          prev_y_r <= in_y;
        end
      end
      pear_pkg::OP_SQX: prod_r <= prod_nxt;
      pear_pkg::OP_SQY: begin
        rad_r  <= prod_r[RW-1:0];
        prod_r <= prod_nxt;
      end
      pear_pkg::OP_SQADD: begin
        rad_r  <= rad_r + prod_r[RW-1:0];
        root_r <= '0;
        rem_r  <= '0;
      end
      pear_pkg::OP_SQRT_STEP: begin
        rad_r  <= {rad_r[RW-3:0], 2'b00};
        rem_r  <= sq_ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[OW-2:0], sq_ge};
      end
      pear_pkg::OP_CUM: prev_cum_r <= cum_wdata;
      pear_pkg::OP_EMIT_START: begin
        n_r   <= n_clamp;
        s_r   <= '0;
        idx_r <= KW'(1);
      end
      pear_pkg::OP_CAP_XY: begin
        res_x_r <= x_rd;
        res_y_r <= y_rd;
      end
      pear_pkg::OP_PUSH: begin
        out_x_r    <= res_x_r;
        out_y_r    <= res_y_r;
        out_last_r <= sts.s_last;
      end
      pear_pkg::OP_NEXT_S: s_r <= s_r + SW'(1);
      pear_pkg::OP_MUL_D,
      pear_pkg::OP_MUL_X,
      pear_pkg::OP_MUL_Y: prod_r <= prod_nxt;
      pear_pkg::OP_DIVN_INIT: begin
        dq_r   <= prod_r;
        drem_r <= '0;
        dden_r <= UW'(n_r);
      end
      pear_pkg::OP_DIVL_INIT: begin
        dq_r   <= prod_r;
        drem_r <= '0;
        dden_r <= len_r;
      end
      pear_pkg::OP_DIV_STEP: begin
        drem_r <= dv_ge ? UW'(dr_sh - {1'b0, dden_r}) : dr_sh[UW-1:0];
        dq_r   <= {dq_r[PW-2:0], dv_ge};
      end
      pear_pkg::OP_SET_D: d_r <= dq_r[UW-1:0];
      pear_pkg::OP_ADV:   idx_r <= idx_r + KW'(1);
      pear_pkg::OP_HIT:   hi_r <= cum_rd;
      pear_pkg::OP_CAP_LO: begin
        base_r <= cum_rd;
        x0_r   <= x_rd;
        y0_r   <= y_rd;
      end
      pear_pkg::OP_CAP_HI: begin
        len_r   <= hi_r - base_r;
        t_r     <= d_r - base_r;
        res_x_r <= x0_r;
        res_y_r <= y0_r;
        mag_x_r <= mag(dif_x);
        mag_y_r <= mag(dif_y);
        neg_x_r <= dif_x[DW-1];
        neg_y_r <= dif_y[DW-1];
      end
      pear_pkg::OP_SET_X:
        res_x_r <= neg_x_r ? (x0_r - dq_r[CW-1:0]) : (x0_r + dq_r[CW-1:0]);
      pear_pkg::OP_SET_Y:
        res_y_r <= neg_y_r ? (y0_r - dq_r[CW-1:0]) : (y0_r + dq_r[CW-1:0]);
      default: ;
    endcase
  end

  always_comb begin
    sts.stored    = stored_r;
    sts.first     = first_r;
    sts.last      = last_r;
    sts.s_last    = (NW'(s_r) + NW'(1)) == n_r;
    sts.out_valid = out_valid_r;
    sts.idx_end   = idx_r >= cnt_r;
    sts.hit       = d_r <= cum_rd;
    sts.len_zero  = len_r == '0;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/pear_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pear_ctrl
// controller: sequences vertex loading and point emission over the datapath
// ----------------------------------------------------------------------------
module pear_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output pear_pkg::pear_cmd_t      cmd,
  input  wire pear_pkg::pear_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_SQX, S_SQY, S_SQADD, S_SQRT, S_CUM,
    S_EMIT, S_CAP0, S_PUSH, S_WAIT, S_FIN, S_NEXT, S_MULD, S_DIVN_INIT,
    S_DIVN, S_SETD, S_SRCH, S_CMP, S_CAPLO, S_CAPHI, S_LENCHK,
    S_MULX, S_DIVX_INIT, S_DIVX, S_SETX, S_MULY, S_DIVY_INIT, S_DIVY, S_SETY
  } state_t;

  localparam int IW = pear_pkg::ITER_W;

  state_t         state_r, state_nxt;
  logic [IW-1:0]  iter_r, iter_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd.op    = pear_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = pear_pkg::OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.stored) begin
          state_nxt = sts.last ? S_EMIT : S_IDLE;
        end else if (sts.first) begin
          state_nxt = S_CUM;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = pear_pkg::OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = pear_pkg::OP_SQY;
        state_nxt = S_SQADD;
      end
      S_SQADD: begin
        cmd.op    = pear_pkg::OP_SQADD;
        iter_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = pear_pkg::OP_SQRT_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(pear_pkg::SQRT_STEPS - 1)) begin
          state_nxt = S_CUM;
        end
      end
      S_CUM: begin
        cmd.op    = pear_pkg::OP_CUM;
        state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.op    = pear_pkg::OP_EMIT_START;
        state_nxt = S_CAP0;
      end
      S_CAP0: begin
        cmd.op    = pear_pkg::OP_CAP_XY;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.op    = pear_pkg::OP_PUSH;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.out_valid) begin
          state_nxt = sts.s_last ? S_FIN : S_NEXT;
        end
      end
      S_FIN: begin
        cmd.op    = pear_pkg::OP_FINISH;
        state_nxt = S_IDLE;
      end
      S_NEXT: begin
        cmd.op    = pear_pkg::OP_NEXT_S;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.op    = pear_pkg::OP_MUL_D;
        state_nxt = S_DIVN_INIT;
      end
      S_DIVN_INIT: begin
        cmd.op    = pear_pkg::OP_DIVN_INIT;
        iter_nxt  = '0;
        state_nxt = S_DIVN;
      end
      S_DIVN: begin
        cmd.op   = pear_pkg::OP_DIV_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(pear_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SETD;
        end
      end
      S_SETD: begin
        cmd.op    = pear_pkg::OP_SET_D;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (sts.idx_end) begin
          cmd.op    = pear_pkg::OP_RD_LAST;
          state_nxt = S_CAP0;
        end else begin
          cmd.op    = pear_pkg::OP_SRCH_RD;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.op    = pear_pkg::OP_HIT;
          state_nxt = S_CAPLO;
        end else begin
          cmd.op    = pear_pkg::OP_ADV;
          state_nxt = S_SRCH;
        end
      end
      S_CAPLO: begin
        cmd.op    = pear_pkg::OP_CAP_LO;
        state_nxt = S_CAPHI;
      end
      S_CAPHI: begin
        cmd.op    = pear_pkg::OP_CAP_HI;
        state_nxt = S_LENCHK;
      end
      S_LENCHK: begin
        state_nxt = sts.len_zero ? S_PUSH : S_MULX;
      end
      S_MULX: begin
        cmd.op    = pear_pkg::OP_MUL_X;
        state_nxt = S_DIVX_INIT;
      end
      S_DIVX_INIT: begin
        cmd.op    = pear_pkg::OP_DIVL_INIT;
        iter_nxt  = '0;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd.op   = pear_pkg::OP_DIV_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(pear_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SETX;
        end
      end
      S_SETX: begin
        cmd.op    = pear_pkg::OP_SET_X;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.op    = pear_pkg::OP_MUL_Y;
        state_nxt = S_DIVY_INIT;
      end
      S_DIVY_INIT: begin
        cmd.op    = pear_pkg::OP_DIVL_INIT;
        iter_nxt  = '0;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cmd.op   = pear_pkg::OP_DIV_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(pear_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SETY;
        end
      end
      S_SETY: begin
        cmd.op    = pear_pkg::OP_SET_Y;
        state_nxt = S_PUSH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule
`default_nettype wire
